>>> sv/sms_udh_pkg.sv
// Package for the SMS user data header port filter.
// Holds the phase and verdict codes, the element codes and the result record.
// Depends on nothing; the core and its testbench import it.
package sms_udh_pkg;

	// Width of the destination port and its value after reset.
	localparam int PORT_W = 16;
	localparam logic [PORT_W-1:0] WANTED_PORT_RESET = 16'd2948;

	// Width of the header length reported with a verdict.
	localparam int HDR_LEN_W = 9;

	// Port addressing elements: identifier and the length that marks them.
	localparam logic [7:0] PORT16_CODE = 8'h05;
	localparam logic [7:0] PORT16_LEN  = 8'd4;
	localparam logic [7:0] PORT8_CODE  = 8'h04;
	localparam logic [7:0] PORT8_LEN   = 8'd2;

	// Parser phase, one-hot.
	typedef enum logic [5:0] {
		PH_LENGTH  = 6'b000001,
		PH_CODE    = 6'b000010,
		PH_ELEN    = 6'b000100,
		PH_DATA    = 6'b001000,
		PH_OVERRUN = 6'b010000,
		PH_DRAIN   = 6'b100000
	} phase_t;

	// Verdict codes as they appear on the result channel.
	typedef enum logic [2:0] {
		V_OK       = 3'd0,
		V_TRUNC    = 3'd1,
		V_OVERRUN  = 3'd2,
		V_DANGLING = 3'd3,
		V_WRONG    = 3'd4
	} verdict_t;

	// One result request.
	typedef struct packed {
		verdict_t               verdict;
		logic [HDR_LEN_W-1:0]   header_len;
		logic                   body_follows;
		logic                   port_seen;
	} result_t;

endpackage

>>> sv/sms_udh_in_if.sv
// Input channel of the SMS header port filter: one payload byte per request.
// Plain valid/ready handshake; no dependencies.
interface sms_udh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       last_byte;

	modport source (output valid, output byte_value, output last_byte, input ready);
	modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

>>> sv/sms_udh_out_if.sv
// Result channel of the SMS header port filter: one verdict per message.
// Plain valid/ready handshake; no dependencies.
interface sms_udh_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] verdict;
	logic [8:0] header_len;
	logic       body_follows;
	logic       port_seen;

	modport source (output valid, output verdict, output header_len, output body_follows,
		output port_seen, input ready);
	modport sink (input valid, input verdict, input header_len, input body_follows,
		input port_seen, output ready);
endinterface

>>> sv/sms_udh_cfg_if.sv
// Configuration write channel of the SMS header port filter.
// Carries the wanted destination port; plain valid/ready handshake, no dependencies.
interface sms_udh_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] wanted_port;

	modport source (output valid, output wanted_port, input ready);
	modport sink (input valid, input wanted_port, output ready);
endinterface

>>> sv/sms_udh_port_filter_core.sv
// SMS user data header port filter. Payload bytes enter one per request on byte_in,
// and a message streams through at one byte per clock while input is not refused.
// The first byte is the header length; the block walks the element chain and
// gives one verdict per message on result, when the header is complete or at the final
// byte if that comes first: ok, truncated, element overrun, dangling byte or wrong port,
// together with the header length plus one, whether body bytes follow and whether a port
// element was seen. The verdict leaves through an output register backed by one skid
// entry, so input is refused only while both hold results that have not been taken.
// Body bytes after the verdict are swallowed up to the final byte. The user must write
// the wanted port on cfg only while no message is in flight (not enforced); reset 2948.
module sms_udh_port_filter_core (
	input  logic                 clk,
	input  logic                 arst_n,
	sms_udh_in_if.sink           byte_in,
	sms_udh_out_if.source        result,
	sms_udh_cfg_if.sink          cfg
);
	import sms_udh_pkg::*;

	// Parser state.
	phase_t              phase_q;
	logic [7:0]          header_left_q;
	logic [7:0]          header_total_q;
	logic [7:0]          element_code_q;
	logic [7:0]          element_len_q;
	logic [7:0]          element_left_q;
	logic [7:0]          port_high_q;
	logic                saw_port_q;
	logic                port_match_q;
	logic [PORT_W-1:0]   wanted_port_q;

	// Output register and skid entry.
	logic                out_valid_q;
	result_t             out_data_q;
	logic                skid_valid_q;
	result_t             skid_data_q;

	// Next-state and result signals.
	phase_t              n_phase;
	logic [7:0]          n_left;
	logic [7:0]          n_total;
	logic [7:0]          n_code;
	logic [7:0]          n_len;
	logic [7:0]          n_eleft;
	logic [7:0]          n_high;
	logic                n_saw;
	logic                n_match;
	logic                emit;
	logic                dangle;
	verdict_t            verd;
	logic                body;
	logic [7:0]          hl_dec;
	logic [7:0]          idx;
	logic                is_p16;
	logic                is_p8;
	logic                accept;
	result_t             res;

	assign accept = byte_in.valid && byte_in.ready;
	assign byte_in.ready = !skid_valid_q;
	assign cfg.ready = 1'b1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_port_q <= WANTED_PORT_RESET;
		end else if (cfg.valid) begin
			wanted_port_q <= cfg.wanted_port;
		end
	end

	// Byte decode: next parser state and the verdict this byte may give.
	always_comb begin
		n_phase = phase_q;
		n_left  = header_left_q;
		n_total = header_total_q;
		n_code  = element_code_q;
		n_len   = element_len_q;
		n_eleft = element_left_q;
		n_high  = port_high_q;
		n_saw   = saw_port_q;
		n_match = port_match_q;
		emit    = 1'b0;
		dangle  = 1'b0;
		verd    = V_OK;
		body    = 1'b0;
		hl_dec  = header_left_q - 8'd1;
		idx     = element_len_q - element_left_q;
		is_p16  = (element_code_q == PORT16_CODE) && (element_len_q == PORT16_LEN);
		is_p8   = (element_code_q == PORT8_CODE) && (element_len_q == PORT8_LEN);
		case (phase_q)
			PH_DRAIN: begin
				if (byte_in.last_byte) n_phase = PH_LENGTH;
			end
			PH_LENGTH: begin
				n_total = byte_in.byte_value;
				n_left  = byte_in.byte_value;
				n_code  = 8'd0;
				n_len   = 8'd0;
				n_eleft = 8'd0;
				n_high  = 8'd0;
				n_saw   = 1'b0;
				n_match = 1'b0;
				if (byte_in.byte_value == 8'd0) begin
					// Empty header: ok on the length byte itself.
					emit    = 1'b1;
					body    = !byte_in.last_byte;
					n_phase = byte_in.last_byte ? PH_LENGTH : PH_DRAIN;
				end else if (byte_in.last_byte) begin
					emit    = 1'b1;
					verd    = V_TRUNC;
					n_phase = PH_LENGTH;
				end else begin
					n_phase = PH_CODE;
				end
			end
			default: begin
				// A header byte.
				n_left = hl_dec;
				case (phase_q)
					PH_CODE: begin
						if (hl_dec == 8'd0) begin
							dangle = 1'b1;
						end else begin
							n_code  = byte_in.byte_value;
							n_phase = PH_ELEN;
						end
					end
					PH_ELEN: begin
						if (byte_in.byte_value > hl_dec) begin
							n_phase = PH_OVERRUN;
						end else begin
							n_len   = byte_in.byte_value;
							n_eleft = byte_in.byte_value;
							n_phase = (byte_in.byte_value == 8'd0) ? PH_CODE : PH_DATA;
						end
					end
					PH_DATA: begin
						if (idx == 8'd0) begin
							n_high = byte_in.byte_value;
							if (is_p8) begin
								n_saw   = 1'b1;
								n_match = ({8'd0, byte_in.byte_value} == wanted_port_q);
							end
						end else if (idx == 8'd1 && is_p16) begin
							n_saw   = 1'b1;
							n_match = ({port_high_q, byte_in.byte_value} == wanted_port_q);
						end
						n_eleft = element_left_q - 8'd1;
						if (n_eleft == 8'd0) n_phase = PH_CODE;
					end
					default: begin
					end
				endcase
				if (hl_dec == 8'd0) begin
					// Header complete.
					if (dangle) begin
						verd = V_DANGLING;
					end else if (n_phase == PH_OVERRUN) begin
						verd = V_OVERRUN;
					end else if (n_saw && !n_match) begin
						verd = V_WRONG;
					end else begin
						verd = V_OK;
					end
					emit    = 1'b1;
					body    = !byte_in.last_byte && (verd == V_OK);
					n_phase = byte_in.last_byte ? PH_LENGTH : PH_DRAIN;
				end else if (byte_in.last_byte) begin
					emit    = 1'b1;
					verd    = V_TRUNC;
					n_phase = PH_LENGTH;
				end
			end
		endcase
		res.verdict      = verd;
		res.header_len   = {1'b0, n_total} + 9'd1;
		res.body_follows = body;
		res.port_seen    = n_saw;
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_LENGTH;
			header_left_q  <= 8'd0;
			header_total_q <= 8'd0;
			element_code_q <= 8'd0;
			element_len_q  <= 8'd0;
			element_left_q <= 8'd0;
			port_high_q    <= 8'd0;
			saw_port_q     <= 1'b0;
			port_match_q   <= 1'b0;
		end else if (accept) begin
			phase_q        <= n_phase;
			header_left_q  <= n_left;
			header_total_q <= n_total;
			element_code_q <= n_code;
			element_len_q  <= n_len;
			element_left_q <= n_eleft;
			port_high_q    <= n_high;
			saw_port_q     <= n_saw;
			port_match_q   <= n_match;
		end
	end

	// Output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept && emit;
			end
		end else if (accept && emit) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || result.ready) begin
			out_data_q <= skid_valid_q ? skid_data_q : res;
		end else if (accept && emit) begin
			skid_data_q <= res;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.verdict      = out_data_q.verdict;
	assign result.header_len   = out_data_q.header_len;
	assign result.body_follows = out_data_q.body_follows;
	assign result.port_seen    = out_data_q.port_seen;

	// The skid entry only fills behind a waiting result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while the output register is empty");

	// A verdict always leaves the parser waiting for a new message or draining the body.
	a_verdict_ends_header: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit) |=> (phase_q == PH_LENGTH || phase_q == PH_DRAIN))
		else $error("parser still inside a header after giving its verdict");

	// Body bytes are only announced with an ok verdict.
	a_body_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.body_follows) |-> (out_data_q.verdict == V_OK))
		else $error("body_follows set with a failing verdict");

	// A waiting result holds until it is taken.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> (out_valid_q && $stable(out_data_q)))
		else $error("result changed before it was taken");

endmodule

>>> verif/tb_sms_udh_port_filter_core.sv
// Testbench for sms_udh_port_filter_core: streams SMS payloads, predicts each verdict
// and checks every result request. Depends on the core, sms_udh_pkg and the three
// channel interfaces.
module tb_sms_udh_port_filter_core;
	import sms_udh_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 6;

	logic clk = 1'b0;
	logic arst_n;

	sms_udh_in_if  byte_in_if ();
	sms_udh_out_if result_if ();
	sms_udh_cfg_if cfg_if ();

	sms_udh_port_filter_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_in(byte_in_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	always #5 clk = ~clk;

	// Verdicts predicted for accepted bytes, oldest first.
	result_t verdicts_due[$];

	// Header parser state as predicted for the block.
	phase_t      hp_phase;
	logic [7:0]  hp_left;
	logic [7:0]  hp_total;
	logic [7:0]  hp_code;
	logic [7:0]  hp_elen;
	logic [7:0]  hp_eleft;
	logic [7:0]  hp_port_hi;
	logic        hp_saw;
	logic        hp_match;
	logic [15:0] hp_wanted;

	// Stimulus state.
	logic [7:0]  chain[$];
	logic [7:0]  payload[$];
	logic [15:0] cur_port;
	bit          idle_on;
	bit          burst_free;
	int          stall_left;
	int          calm_left;
	int          cycle_count;
	int          n_errors;
	int          n_bytes;
	int          n_messages;
	int          n_settings;
	int          n_checked;
	int          verdict_count[5];

	// Builds the result record for a verdict from the predicted state.
	function automatic result_t verdict_record(input verdict_t v, input logic body);
		result_t r;
		r.verdict      = v;
		r.header_len   = {1'b0, hp_total} + 9'd1;
		r.body_follows = (v == V_OK) && body;
		r.port_seen    = hp_saw;
		return r;
	endfunction

	// Advances the predicted parser by one accepted byte; returns 1 when a verdict is due.
	function automatic bit udh_track_byte(input logic [7:0] b, input logic last,
		output result_t r);
		verdict_t   v;
		logic [7:0] idx;
		v = V_OK;
		r = '0;
		// Body bytes after the verdict are swallowed up to the final byte.
		if (hp_phase == PH_DRAIN) begin
			if (last)
				hp_phase = PH_LENGTH;
			return 1'b0;
		end
		// The length byte opens a new message.
		if (hp_phase == PH_LENGTH) begin
			hp_total   = b;
			hp_left    = b;
			hp_code    = '0;
			hp_elen    = '0;
			hp_eleft   = '0;
			hp_port_hi = '0;
			hp_saw     = 1'b0;
			hp_match   = 1'b0;
			if (b == 8'd0) begin
				hp_phase = last ? PH_LENGTH : PH_DRAIN;
				r = verdict_record(V_OK, !last);
				return 1'b1;
			end
			if (last) begin
				hp_phase = PH_LENGTH;
				r = verdict_record(V_TRUNC, 1'b0);
				return 1'b1;
			end
			hp_phase = PH_CODE;
			return 1'b0;
		end
		// A header byte.
		hp_left = hp_left - 8'd1;
		case (hp_phase)
			PH_CODE: begin
				if (hp_left == 8'd0) begin
					v = V_DANGLING;
				end else begin
					hp_code  = b;
					hp_phase = PH_ELEN;
				end
			end
			PH_ELEN: begin
				if (b > hp_left) begin
					hp_phase = PH_OVERRUN;
				end else begin
					hp_elen  = b;
					hp_eleft = b;
					hp_phase = (b == 8'd0) ? PH_CODE : PH_DATA;
				end
			end
			PH_DATA: begin
				idx = hp_elen - hp_eleft;
				if (idx == 8'd0) begin
					hp_port_hi = b;
					if (hp_code == PORT8_CODE && hp_elen == PORT8_LEN) begin
						hp_saw   = 1'b1;
						hp_match = ({8'h00, b} == hp_wanted);
					end
				end else if (idx == 8'd1 && hp_code == PORT16_CODE && hp_elen == PORT16_LEN) begin
					hp_saw   = 1'b1;
					hp_match = ({hp_port_hi, b} == hp_wanted);
				end
				hp_eleft = hp_eleft - 8'd1;
				if (hp_eleft == 8'd0)
					hp_phase = PH_CODE;
			end
			default: ;
		endcase
		// Header complete: the verdict follows from what the chain showed.
		if (hp_left == 8'd0) begin
			if (v == V_OK && hp_phase == PH_OVERRUN)
				v = V_OVERRUN;
			if (v == V_OK && hp_saw && !hp_match)
				v = V_WRONG;
			hp_phase = last ? PH_LENGTH : PH_DRAIN;
			r = verdict_record(v, !last);
			return 1'b1;
		end
		if (last) begin
			hp_phase = PH_LENGTH;
			r = verdict_record(V_TRUNC, 1'b0);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Sends one payload byte and records the verdict it is expected to cause.
	task automatic send_byte(input logic [7:0] b, input logic last);
		result_t r;
		int      gap;
		if (idle_on && !burst_free && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 17);
			byte_in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_in_if.valid      <= 1'b1;
		byte_in_if.byte_value <= b;
		byte_in_if.last_byte  <= last;
		@(posedge clk);
		while (!byte_in_if.ready) @(posedge clk);
		if (udh_track_byte(b, last, r))
			verdicts_due.push_back(r);
		n_bytes++;
	endtask

	// Sends the bytes in payload as one message, the final one flagged.
	task automatic send_message();
		burst_free = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < payload.size(); i++)
			send_byte(payload[i], i == payload.size() - 1);
		n_messages++;
	endtask

	// Stops sending, waits for every verdict and lets the block come to rest.
	task automatic settle_block();
		byte_in_if.valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the wanted port while the block is idle.
	task automatic set_wanted_port(input logic [15:0] p);
		settle_block();
		cfg_if.valid       <= 1'b1;
		cfg_if.wanted_port <= p;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		hp_wanted = p;
		cur_port  = p;
		n_settings++;
	endtask

	// Appends an element with random data to the header chain.
	function automatic void add_element(input logic [7:0] code, input int len);
		chain.push_back(code);
		chain.push_back(8'(len));
		for (int i = 0; i < len; i++)
			chain.push_back(8'($urandom_range(0, 255)));
	endfunction

	// Appends a port element naming the wanted port about half the time.
	function automatic void add_port_element(input bit wide);
		logic [15:0] p;
		int          at;
		p  = $urandom_range(0, 1) ? cur_port : 16'($urandom_range(0, 65535));
		at = chain.size() + 2;
		if (wide) begin
			add_element(PORT16_CODE, PORT16_LEN);
			chain[at]     = p[15:8];
			chain[at + 1] = p[7:0];
		end else begin
			add_element(PORT8_CODE, PORT8_LEN);
			chain[at] = p[7:0];
		end
	endfunction

	// Builds a chain of port and other elements.
	function automatic void build_chain(input int n);
		logic [7:0] code;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: add_port_element(1'b1);
				1: add_port_element(1'b0);
				default: begin
					code = $urandom_range(0, 2) == 0 ?
						($urandom_range(0, 1) ? PORT8_CODE : PORT16_CODE) :
						8'($urandom_range(0, 255));
					add_element(code, $urandom_range(0, 6));
				end
			endcase
		end
	endfunction

	// Builds one random message: mostly well-formed headers followed by up to five body
	// bytes, the rest overrun, dangling, truncated or plain noise.
	task automatic build_random_message();
		int kind;
		int room;
		int keep;
		bit cut;
		chain.delete();
		payload.delete();
		kind = $urandom_range(0, 15);
		if (kind == 15) begin
			payload.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 12)) :
				8'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 9)) payload.push_back(8'($urandom_range(0, 255)));
			return;
		end
		build_chain($urandom_range(0, 4));
		if (kind == 12) begin
			// An element whose length runs past the end of the header.
			room = $urandom_range(0, 3);
			chain.push_back(8'($urandom_range(0, 255)));
			chain.push_back(8'($urandom_range(room + 1, 255)));
			repeat (room) chain.push_back(8'($urandom_range(0, 255)));
		end else if (kind == 13) begin
			chain.push_back(8'($urandom_range(0, 255)));
		end
		payload.push_back(8'(chain.size()));
		foreach (chain[i]) payload.push_back(chain[i]);
		cut = (kind == 14) || (kind == 12 && $urandom_range(0, 2) == 0);
		if (cut && chain.size() > 0) begin
			keep = $urandom_range(0, chain.size() - 1);
			while (payload.size() > keep + 1) void'(payload.pop_back());
		end else begin
			repeat ($urandom_range(0, 5)) payload.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_random_until(input int target);
		while (n_bytes < target) begin
			build_random_message();
			send_message();
		end
	endtask

	// Empty header, body bytes, matching and wrong ports, truncation, overrun, dangling byte.
	task automatic test_directed();
		payload = '{8'h00};
		send_message();
		payload = '{8'h00, 8'hAA, 8'hFF};
		send_message();
		payload = '{8'h06, PORT16_CODE, PORT16_LEN, 8'h0B, 8'h84, 8'h00, 8'h00, 8'h55};
		send_message();
		payload = '{8'h04, PORT8_CODE, PORT8_LEN, 8'h12, 8'h34};
		send_message();
		payload = '{8'h05, 8'h01};
		send_message();
		payload = '{8'h03, 8'h07, 8'hFF, 8'h01};
		send_message();
		payload = '{8'h03, 8'h00, 8'h00, 8'h09};
		send_message();
	endtask

	// Several wanted ports, the extremes among them, each with random traffic.
	task automatic test_port_settings();
		logic [15:0] ports[5];
		ports = '{16'h0000, 16'hFFFF, 16'h0037, 16'($urandom_range(1, 65534)), 16'h0001};
		foreach (ports[i]) begin
			set_wanted_port(ports[i]);
			run_random_until(n_bytes + 90);
		end
	endtask

	// The longest header the length byte allows, opening with a matching port.
	task automatic test_long_header();
		set_wanted_port(WANTED_PORT_RESET);
		chain.delete();
		payload.delete();
		chain = '{PORT16_CODE, PORT16_LEN, cur_port[15:8], cur_port[7:0], 8'h00, 8'h00};
		add_element(8'h7E, 247);
		payload.push_back(8'(chain.size()));
		foreach (chain[i]) payload.push_back(chain[i]);
		payload.push_back(8'hC3);
		send_message();
	endtask

	task automatic test_random_traffic();
		set_wanted_port(16'($urandom_range(0, 1) ? $urandom_range(0, 255) :
			$urandom_range(0, 65535)));
		run_random_until(1250);
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_full_rate();
		idle_on = 1'b0;
		run_random_until(1450);
	endtask

	// Result channel stalls in bursts, with calm stretches in between.
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (calm_left > 0)
			calm_left--;
		else if ($urandom_range(0, 15) == 0)
			calm_left = $urandom_range(20, 150);
		else if ($urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 17);
		result_if.ready <= !(idle_on && arst_n && stall_left > 0);
	end

	// Each accepted result request is compared with the oldest prediction.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (verdicts_due.size() == 0) begin
				$error("unexpected verdict %0d with no message pending", result_if.verdict);
				n_errors++;
			end else begin
				want = verdicts_due.pop_front();
				n_checked++;
				if (want.verdict <= V_WRONG)
					verdict_count[want.verdict]++;
				if (result_if.verdict !== want.verdict) begin
					$error("verdict: expected %0d, got %0d", want.verdict, result_if.verdict);
					n_errors++;
				end
				if (result_if.header_len !== want.header_len) begin
					$error("header_len: expected %0d, got %0d", want.header_len,
						result_if.header_len);
					n_errors++;
				end
				if (result_if.body_follows !== want.body_follows) begin
					$error("body_follows: expected %0b, got %0b", want.body_follows,
						result_if.body_follows);
					n_errors++;
				end
				if (result_if.port_seen !== want.port_seen) begin
					$error("port_seen: expected %0b, got %0b", want.port_seen,
						result_if.port_seen);
					n_errors++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit with %0d verdicts outstanding",
				verdicts_due.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		byte_in_if.valid      = 1'b0;
		byte_in_if.byte_value = '0;
		byte_in_if.last_byte  = 1'b0;
		cfg_if.valid          = 1'b0;
		cfg_if.wanted_port    = '0;
		arst_n                = 1'b0;
		idle_on               = 1'b1;
		burst_free            = 1'b0;
		cur_port              = WANTED_PORT_RESET;
		hp_wanted             = WANTED_PORT_RESET;
		hp_phase              = PH_LENGTH;
		hp_left               = '0;
		hp_total              = '0;
		hp_code               = '0;
		hp_elen               = '0;
		hp_eleft              = '0;
		hp_port_hi            = '0;
		hp_saw                = 1'b0;
		hp_match              = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_port_settings();
		test_long_header();
		test_random_traffic();
		test_full_rate();

		byte_in_if.valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes in %0d messages under %0d port settings; %0d verdicts checked",
			n_bytes, n_messages, n_settings, n_checked);
		$display("Verdicts: ok %0d, truncated %0d, overrun %0d, dangling %0d, wrong port %0d",
			verdict_count[V_OK], verdict_count[V_TRUNC], verdict_count[V_OVERRUN],
			verdict_count[V_DANGLING], verdict_count[V_WRONG]);
		if (n_errors == 0 && verdicts_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
